// File: design/stt_pkg.sv
package stt_pkg;

  // field widths
  localparam int OFFSET_WIDTH = 24;
  localparam int LINE_WIDTH   = 16;
  localparam int KIND_WIDTH   = 5;
  localparam int BYTE_WIDTH   = 8;

  // result item packing in m_tdata, lowest field first
  localparam int TOK_BITS   = KIND_WIDTH + 2 * OFFSET_WIDTH + 2 * LINE_WIDTH;
  localparam int TDATA_W    = ((TOK_BITS + 7) / 8) * 8;
  localparam int START_LSB  = KIND_WIDTH;
  localparam int LEN_LSB    = START_LSB + OFFSET_WIDTH;
  localparam int LINE_LSB   = LEN_LSB + OFFSET_WIDTH;
  localparam int COL_LSB    = LINE_LSB + LINE_WIDTH;
  localparam int SRC_TDATA_W = BYTE_WIDTH;

  // token kinds
  typedef enum logic [KIND_WIDTH-1:0] {
    K_LPAREN  = 5'd0,  K_RPAREN  = 5'd1,  K_LCURLY  = 5'd2,  K_RCURLY = 5'd3,
    K_LSQUAR  = 5'd4,  K_RSQUAR  = 5'd5,  K_COMMA   = 5'd6,  K_DOT    = 5'd7,
    K_PLUS    = 5'd8,  K_MINUS   = 5'd9,  K_STAR    = 5'd10, K_SLASH  = 5'd11,
    K_CARET   = 5'd12, K_MOD     = 5'd13, K_ASSIGN  = 5'd14, K_COLON  = 5'd15,
    K_SEMI    = 5'd16, K_QUEST   = 5'd17, K_GE      = 5'd18, K_GTGT   = 5'd19,
    K_GT      = 5'd20, K_LE      = 5'd21, K_LTLT    = 5'd22, K_LT     = 5'd23,
    K_EQ      = 5'd24, K_NE      = 5'd25, K_NOT     = 5'd26, K_STRING = 5'd27,
    K_INTEGER = 5'd28, K_FLOAT   = 5'd29, K_IDENT   = 5'd30, K_UNTERM = 5'd31
  } kind_t;

  // character codes
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LCURLY = 8'h7b;
  localparam logic [7:0] CH_RCURLY = 8'h7d;
  localparam logic [7:0] CH_LSQUAR = 8'h5b;
  localparam logic [7:0] CH_RSQUAR = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_DOT    = 8'h2e;
  localparam logic [7:0] CH_PLUS   = 8'h2b;
  localparam logic [7:0] CH_STAR   = 8'h2a;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_CARET  = 8'h5e;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_SEMI   = 8'h3b;
  localparam logic [7:0] CH_QUEST  = 8'h3f;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_MINUS  = 8'h2d;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_GT     = 8'h3e;
  localparam logic [7:0] CH_LT     = 8'h3c;
  localparam logic [7:0] CH_EQ     = 8'h3d;
  localparam logic [7:0] CH_TILDE  = 8'h7e;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_NL     = 8'h0a;
  localparam logic [7:0] CH_UNDER  = 8'h5f;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7a;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5a;

endpackage

// File: design/source_text_tokenizer_unit.sv
// Source text tokenizer: streaming lexical scanner.
// Input channel s_*: one ASCII byte per item in s_tdata, s_tlast on the last
// byte of a source text. Output channel m_*: one token per item, m_tlast on
// the last token caused by a given input byte.
// Each accepted byte is scanned in the same cycle by the mode logic, and the
// zero to three tokens it causes are written into a four-entry result queue.
// If the queue was empty, the first of them is on m_* in the cycle after
// the byte is accepted. s_tready is high while the queue holds at most one
// token, so one byte per cycle is taken as long as each byte causes at most
// one token and the receiver takes one token per cycle. With m_tready high,
// the output moves one token per cycle: the rate when bytes cause more.
// A byte with s_tlast flushes any pending token (an open string comes out as
// an unterminated string, an open comment gives nothing) and returns the
// scanner to its starting state, so the next byte begins a new text.
// Reset empties the queue and sets offset 0, line 1, column 1, idle mode.
// When the receiver stalls, the queue fills and s_tready drops; no token is
// lost or repeated.
module source_text_tokenizer_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [stt_pkg::SRC_TDATA_W-1:0] s_tdata,  // [7:0] source_byte
  input  logic                          s_tlast,   // end_of_source
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [4:0] token_kind, then start_offset, token_length, line_number,
  // column_number, zero fill up to whole bytes
  output logic [stt_pkg::TDATA_W-1:0]   m_tdata,
  output logic                          m_tlast    // last_of_run
);
  import stt_pkg::*;

  localparam int OW         = OFFSET_WIDTH;
  localparam int LW         = LINE_WIDTH;
  localparam int SUM_W      = ((OW > LW) ? OW : LW) + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CNT_W      = 3;
  localparam int MAX_PUSH   = 3;
  localparam int NCAND      = 5;
  localparam logic [LW-1:0] LINE_MAX = '1;

  typedef enum logic [12:0] {
    M_IDLE    = 13'b0000000000001,
    M_COMMENT = 13'b0000000000010,
    M_STRING  = 13'b0000000000100,
    M_INT     = 13'b0000000001000,
    M_DOT     = 13'b0000000010000,
    M_FRAC    = 13'b0000000100000,
    M_IDENT   = 13'b0000001000000,
    M_MINUS   = 13'b0000010000000,
    M_COLON   = 13'b0000100000000,
    M_GT      = 13'b0001000000000,
    M_LT      = 13'b0010000000000,
    M_EQ      = 13'b0100000000000,
    M_TILDE   = 13'b1000000000000
  } mode_t;

  typedef struct packed {
    logic          last;
    logic [LW-1:0] col;
    logic [LW-1:0] line;
    logic [OW-1:0] len;
    logic [OW-1:0] start;
    kind_t         kind;
  } tok_t;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CH_0) && (b <= CH_9);
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return ((b >= CH_LA) && (b <= CH_LZ)) || ((b >= CH_UA) && (b <= CH_UZ));
  endfunction

  function automatic logic [LW-1:0] col_add(logic [LW-1:0] c, logic [OW-1:0] d);
    logic [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(d);
    return (s > SUM_W'(LINE_MAX)) ? LINE_MAX : s[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] sat_inc(logic [LW-1:0] v);
    return (v == LINE_MAX) ? v : v + LW'(1);
  endfunction

  // scanner state
  mode_t         mode, mode_next;
  logic          quote_single, quote_single_next;
  logic [OW-1:0] cur_ofs, cur_ofs_next;
  logic [OW-1:0] tok_start, tok_start_next;
  logic [LW-1:0] cur_line, cur_line_next;
  logic [LW-1:0] cur_col, cur_col_next;
  logic [LW-1:0] st_line, st_line_next;
  logic [LW-1:0] st_col, st_col_next;

  // result queue
  tok_t               fifo [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count, count_next;

  logic [7:0] src;
  logic       eos;
  logic       accept, pop;
  logic       again;
  mode_t      mode_mid;
  logic [OW-1:0] after, len_here, len_incl, dot_ofs, int_len, int_len_f, len_fl;
  tok_t       cand [NCAND];
  logic [NCAND-1:0] cand_v;
  logic [CNT_W-1:0] pos [NCAND];
  logic [CNT_W-1:0] n_valid, n_push;

  assign src      = s_tdata[7:0];
  assign eos      = s_tlast;
  assign s_tready = (count <= CNT_W'(FIFO_DEPTH - MAX_PUSH));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;

  // scan one byte: pending token, fresh idle scan, end-of-text flush
  always_comb begin
    after     = cur_ofs + OW'(1);
    len_here  = cur_ofs - tok_start;
    len_incl  = after - tok_start;
    dot_ofs   = cur_ofs - OW'(1);
    int_len   = dot_ofs - tok_start;
    again     = 1'b0;
    mode_mid  = mode;
    quote_single_next = quote_single;
    tok_start_next = tok_start;
    st_line_next   = st_line;
    st_col_next    = st_col;
    cand_v    = '0;
    for (int i = 0; i < NCAND; i++) begin
      cand[i] = '{last: 1'b0, col: st_col, line: st_line, len: len_here,
                  start: tok_start, kind: K_LPAREN};
    end

    // pending token from the current mode
    unique case (mode)
      M_IDLE: again = 1'b1;
      M_COMMENT: begin
        if (src == CH_NL) begin
          mode_mid = M_IDLE;
          again    = 1'b1;
        end
      end
      M_STRING: begin
        if (src == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
          cand_v[0]    = 1'b1;
          cand[0].kind = K_STRING;
          cand[0].len  = len_incl;
          mode_mid     = M_IDLE;
        end
      end
      M_INT: begin
        if (src == CH_DOT) begin
          mode_mid = M_DOT;
        end else if (!is_digit(src)) begin
          cand_v[0]    = 1'b1;
          cand[0].kind = K_INTEGER;
          mode_mid     = M_IDLE;
          again        = 1'b1;
        end
      end
      M_DOT: begin
        if (is_digit(src)) begin
          mode_mid = M_FRAC;
        end else begin
          // integer, then the dot on its own
          cand_v[1:0]   = 2'b11;
          cand[0].kind  = K_INTEGER;
          cand[0].len   = int_len;
          cand[1].kind  = K_DOT;
          cand[1].start = dot_ofs;
          cand[1].len   = OW'(1);
          cand[1].col   = col_add(st_col, int_len);
          mode_mid      = M_IDLE;
          again         = 1'b1;
        end
      end
      M_FRAC: begin
        if (!is_digit(src)) begin
          cand_v[0]    = 1'b1;
          cand[0].kind = K_FLOAT;
          mode_mid     = M_IDLE;
          again        = 1'b1;
        end
      end
      M_IDENT: begin
        if (!(is_digit(src) || is_letter(src) || (src == CH_UNDER))) begin
          cand_v[0]    = 1'b1;
          cand[0].kind = K_IDENT;
          mode_mid     = M_IDLE;
          again        = 1'b1;
        end
      end
      M_MINUS: begin
        if (src == CH_MINUS) begin
          mode_mid = M_COMMENT;
        end else begin
          cand_v[0]    = 1'b1;
          cand[0].kind = K_MINUS;
          mode_mid     = M_IDLE;
          again        = 1'b1;
        end
      end
      M_COLON, M_GT, M_LT, M_EQ, M_TILDE: begin
        mode_mid = M_IDLE;
        if (src == CH_EQ) begin
          cand_v[0]   = 1'b1;
          cand[0].len = len_incl;
          unique case (mode)
            M_COLON: cand[0].kind = K_ASSIGN;
            M_GT:    cand[0].kind = K_GE;
            M_LT:    cand[0].kind = K_LE;
            M_EQ:    cand[0].kind = K_EQ;
            default: cand[0].kind = K_NE;
          endcase
        end else if ((mode == M_GT && src == CH_GT) || (mode == M_LT && src == CH_LT)) begin
          cand_v[0]    = 1'b1;
          cand[0].len  = len_incl;
          cand[0].kind = (mode == M_GT) ? K_GTGT : K_LTLT;
        end else begin
          // single form; a lone '=' gives nothing
          cand_v[0] = (mode != M_EQ);
          again     = 1'b1;
          unique case (mode)
            M_COLON: cand[0].kind = K_COLON;
            M_GT:    cand[0].kind = K_GT;
            M_LT:    cand[0].kind = K_LT;
            default: cand[0].kind = K_NOT;
          endcase
        end
      end
      default: begin
        mode_mid = M_IDLE;
        again    = 1'b1;
      end
    endcase

    // byte scanned afresh in idle mode
    mode_next = mode_mid;
    cand[2].start = cur_ofs;
    cand[2].len   = OW'(1);
    cand[2].line  = cur_line;
    cand[2].col   = cur_col;
    if (again) begin
      tok_start_next = cur_ofs;
      st_line_next   = cur_line;
      st_col_next    = cur_col;
      cand_v[2]      = 1'b1;
      case (src)
        CH_LPAREN: cand[2].kind = K_LPAREN;
        CH_RPAREN: cand[2].kind = K_RPAREN;
        CH_LCURLY: cand[2].kind = K_LCURLY;
        CH_RCURLY: cand[2].kind = K_RCURLY;
        CH_LSQUAR: cand[2].kind = K_LSQUAR;
        CH_RSQUAR: cand[2].kind = K_RSQUAR;
        CH_COMMA:  cand[2].kind = K_COMMA;
        CH_DOT:    cand[2].kind = K_DOT;
        CH_PLUS:   cand[2].kind = K_PLUS;
        CH_STAR:   cand[2].kind = K_STAR;
        CH_SLASH:  cand[2].kind = K_SLASH;
        CH_CARET:  cand[2].kind = K_CARET;
        CH_PCT:    cand[2].kind = K_MOD;
        CH_SEMI:   cand[2].kind = K_SEMI;
        CH_QUEST:  cand[2].kind = K_QUEST;
        default: begin
          cand_v[2] = 1'b0;
          case (src)
            CH_HASH:  mode_next = M_COMMENT;
            CH_MINUS: mode_next = M_MINUS;
            CH_COLON: mode_next = M_COLON;
            CH_GT:    mode_next = M_GT;
            CH_LT:    mode_next = M_LT;
            CH_EQ:    mode_next = M_EQ;
            CH_TILDE: mode_next = M_TILDE;
            CH_DQUOTE: begin
              mode_next         = M_STRING;
              quote_single_next = 1'b0;
            end
            CH_SQUOTE: begin
              mode_next         = M_STRING;
              quote_single_next = 1'b1;
            end
            default: begin
              if (is_digit(src)) begin
                mode_next = M_INT;
              end else if (is_letter(src)) begin
                mode_next = M_IDENT;
              end
            end
          endcase
        end
      endcase
    end

    // position counters
    cur_ofs_next = after;
    if (src == CH_NL) begin
      cur_line_next = sat_inc(cur_line);
      cur_col_next  = LW'(1);
    end else begin
      cur_line_next = cur_line;
      cur_col_next  = sat_inc(cur_col);
    end

    // end of text: flush what is pending, then back to the start state
    len_fl    = after - tok_start_next;
    int_len_f = cur_ofs - tok_start_next;
    for (int i = 3; i < NCAND; i++) begin
      cand[i].start = tok_start_next;
      cand[i].len   = len_fl;
      cand[i].line  = st_line_next;
      cand[i].col   = st_col_next;
    end
    if (eos) begin
      cand_v[3] = 1'b1;
      case (mode_next)
        M_STRING: cand[3].kind = K_UNTERM;
        M_INT:    cand[3].kind = K_INTEGER;
        M_FRAC:   cand[3].kind = K_FLOAT;
        M_IDENT:  cand[3].kind = K_IDENT;
        M_MINUS:  cand[3].kind = K_MINUS;
        M_COLON:  cand[3].kind = K_COLON;
        M_GT:     cand[3].kind = K_GT;
        M_LT:     cand[3].kind = K_LT;
        M_TILDE:  cand[3].kind = K_NOT;
        M_DOT: begin
          cand_v[4]     = 1'b1;
          cand[3].kind  = K_INTEGER;
          cand[3].len   = int_len_f;
          cand[4].kind  = K_DOT;
          cand[4].start = cur_ofs;
          cand[4].len   = OW'(1);
          cand[4].col   = col_add(st_col_next, int_len_f);
        end
        default: cand_v[3] = 1'b0;
      endcase
      mode_next         = M_IDLE;
      quote_single_next = 1'b0;
      cur_ofs_next      = '0;
      tok_start_next    = '0;
      cur_line_next     = LW'(1);
      cur_col_next      = LW'(1);
      st_line_next      = LW'(1);
      st_col_next       = LW'(1);
    end

    // pack the tokens into queue order and mark the last one
    pos[0] = '0;
    for (int i = 1; i < NCAND; i++) begin
      pos[i] = pos[i-1] + CNT_W'(cand_v[i-1]);
    end
    n_valid = pos[NCAND-1] + CNT_W'(cand_v[NCAND-1]);
    // at most three tokens per byte, any further ones are dropped
    n_push  = (n_valid > CNT_W'(MAX_PUSH)) ? CNT_W'(MAX_PUSH) : n_valid;
    for (int i = 0; i < NCAND; i++) begin
      cand[i].last = (pos[i] == n_push - CNT_W'(1));
    end

    count_next = count - CNT_W'(pop) + (accept ? n_push : CNT_W'(0));
  end

  // scanner state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_IDLE;
      quote_single <= 1'b0;
      cur_ofs      <= '0;
      tok_start    <= '0;
      cur_line     <= LW'(1);
      cur_col      <= LW'(1);
      st_line      <= LW'(1);
      st_col       <= LW'(1);
    end else if (accept) begin
      mode         <= mode_next;
      quote_single <= quote_single_next;
      cur_ofs      <= cur_ofs_next;
      tok_start    <= tok_start_next;
      cur_line     <= cur_line_next;
      cur_col      <= cur_col_next;
      st_line      <= st_line_next;
      st_col       <= st_col_next;
    end
  end

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (accept) begin
        wr_ptr <= wr_ptr + n_push[FIFO_AW-1:0];
      end
      if (pop) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NCAND; i++) begin
        if (cand_v[i] && (pos[i] < CNT_W'(MAX_PUSH))) begin
          fifo[wr_ptr + pos[i][FIFO_AW-1:0]] <= cand[i];
        end
      end
    end
  end

  // result item
  assign m_tdata = {(TDATA_W - TOK_BITS)'(0), fifo[rd_ptr].col, fifo[rd_ptr].line,
                    fifo[rd_ptr].len, fifo[rd_ptr].start, fifo[rd_ptr].kind};
  assign m_tlast = fifo[rd_ptr].last;

endmodule

// File: design/stt_checker.sv
module stt_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic [stt_pkg::SRC_TDATA_W-1:0] s_tdata,
  input logic                            s_tlast,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [stt_pkg::TDATA_W-1:0]     m_tdata,
  input logic                            m_tlast
);
  import stt_pkg::*;

  logic [LINE_WIDTH-1:0] tok_line, tok_col;

  assign tok_line = m_tdata[LINE_LSB +: LINE_WIDTH];
  assign tok_col  = m_tdata[COL_LSB +: LINE_WIDTH];

  // queue comes out of reset empty
  a_empty_after_rst: assert property (@(posedge clk) disable iff (rst)
    $fell(rst) |-> !m_tvalid)
    else $error("result pending right after reset");

  // an empty queue always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with nothing queued");

  // line and column are one-based and never wrap to zero
  a_pos_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (tok_line != '0) && (tok_col != '0))
    else $error("token with zero line or column");

  // a stalled result item holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result item changed while stalled");

endmodule

bind source_text_tokenizer_unit stt_checker u_stt_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
